### sv/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants of the spring and bungee force unit.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Three axes: x, y, z.
    localparam int AXES = 3;

    // Configuration registers are 31 bits wide.
    localparam int REG_W      = 31;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [REG_W-1:0] SPRING_CONSTANT_RST = 31'd65536;
    localparam logic [REG_W-1:0] REST_LENGTH_RST     = 31'd65536;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SPRING_CONSTANT = 1'b0,
        REG_REST_LENGTH     = 1'b1
    } cfg_reg_t;

    // Pipeline control handed to a pipelined unit.
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

### sv/sbf_sqrt.sv
// ----------------------------------------------------------------------------
// sbf_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module sbf_sqrt #(
    parameter int IN_W   = 66,
    parameter int ROOT_W = 33,
    parameter int SB_W   = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbf_pkg::pipe_ctl_t    ctl,
    input  logic [IN_W-1:0]       radicand,
    input  logic [SB_W-1:0]       sb_in,
    output logic                  valid_out,
    output logic [ROOT_W-1:0]     root,
    output logic [SB_W-1:0]       sb_out
);

    logic [ROOT_W:1]   vld_reg;
    logic [IN_W-1:0]   rem_reg  [1:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];
    logic [SB_W-1:0]   sb_reg   [1:ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic              src_vld;
        logic [IN_W-1:0]   src_rem;
        logic [ROOT_W-1:0] src_root;
        logic [SB_W-1:0]   src_sb;
        logic [IN_W:0]     trial;
        logic              take;
        logic [IN_W-1:0]   rem_next;
        logic [ROOT_W-1:0] root_next;

        if (j == 0) begin : g_first
            assign src_vld  = ctl.valid;
            assign src_rem  = radicand;
            assign src_root = '0;
            assign src_sb   = sb_in;
        end else begin : g_mid
            assign src_vld  = vld_reg[j];
            assign src_rem  = rem_reg[j];
            assign src_root = root_reg[j];
            assign src_sb   = sb_reg[j];
        end

        // Setting bit B grows the square by root*2^(B+1) + 2^(2B).
        assign trial = ((IN_W+1)'(src_root) << (B + 1)) + ((IN_W+1)'(1) << (2 * B));
        assign take  = {1'b0, src_rem} >= trial;
        assign rem_next  = take ? (src_rem - trial[IN_W-1:0]) : src_rem;
        assign root_next = take ? (src_root | (ROOT_W'(1) << B)) : src_root;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[j+1] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                root_reg[j+1] <= root_next;
                sb_reg[j+1]   <= src_sb;
            end
        end

        if (j < ROOT_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rem_reg[j+1] <= rem_next;
                end
            end
        end else begin : g_norem
            // The final remainder is not needed.
        end
    end

    assign valid_out = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign sb_out    = sb_reg[ROOT_W];

endmodule

### sv/sbf_div.sv
// ----------------------------------------------------------------------------
// sbf_div
// Pipelined restoring divider, one quotient bit per stage, three numerators
// over one shared divisor, with sideband.
// ----------------------------------------------------------------------------
module sbf_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 33,
    parameter int QUO_W = 32,
    parameter int SB_W  = 1
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  sbf_pkg::pipe_ctl_t                        ctl,
    input  logic [sbf_pkg::AXES-1:0][NUM_W-1:0]       num,
    input  logic [DEN_W-1:0]                          den,
    input  logic [SB_W-1:0]                           sb_in,
    output logic                                      valid_out,
    output logic [sbf_pkg::AXES-1:0][QUO_W-1:0]       quo,
    output logic [SB_W-1:0]                           sb_out
);

    logic [QUO_W:1]                                vld_reg;
    logic [sbf_pkg::AXES-1:0][NUM_W-1:0]           rem_reg [1:QUO_W-1];
    logic [DEN_W-1:0]                              den_reg [1:QUO_W-1];
    logic [sbf_pkg::AXES-1:0][QUO_W-1:0]           quo_reg [1:QUO_W];
    logic [SB_W-1:0]                               sb_reg  [1:QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int B = QUO_W - 1 - j;
        logic                                src_vld;
        logic [sbf_pkg::AXES-1:0][NUM_W-1:0] src_rem;
        logic [DEN_W-1:0]                    src_den;
        logic [sbf_pkg::AXES-1:0][QUO_W-1:0] src_quo;
        logic [SB_W-1:0]                     src_sb;
        logic [NUM_W-1:0]                    shifted;
        logic [sbf_pkg::AXES-1:0][NUM_W-1:0] rem_next;
        logic [sbf_pkg::AXES-1:0][QUO_W-1:0] quo_next;

        if (j == 0) begin : g_first
            assign src_vld = ctl.valid;
            assign src_rem = num;
            assign src_den = den;
            assign src_quo = '0;
            assign src_sb  = sb_in;
        end else begin : g_mid
            assign src_vld = vld_reg[j];
            assign src_rem = rem_reg[j];
            assign src_den = den_reg[j];
            assign src_quo = quo_reg[j];
            assign src_sb  = sb_reg[j];
        end

        assign shifted = NUM_W'(src_den) << B;

        always_comb
        begin
            for (int i = 0; i < sbf_pkg::AXES; i++)
            begin
                if (src_rem[i] >= shifted)
                begin
                    rem_next[i] = src_rem[i] - shifted;
                    quo_next[i] = src_quo[i] | (QUO_W'(1) << B);
                end
                else
                begin
                    rem_next[i] = src_rem[i];
                    quo_next[i] = src_quo[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (ctl.en)
            begin
                vld_reg[j+1] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                quo_reg[j+1] <= quo_next;
                sb_reg[j+1]  <= src_sb;
            end
        end

        if (j < QUO_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rem_reg[j+1] <= rem_next;
                    den_reg[j+1] <= src_den;
                end
            end
        end else begin : g_norem
            // The final remainder is not needed.
        end
    end

    assign valid_out = vld_reg[QUO_W];
    assign quo       = quo_reg[QUO_W];
    assign sb_out    = sb_reg[QUO_W];

endmodule

### sv/spring_bungee_force.sv
// ----------------------------------------------------------------------------
// spring_bungee_force
// Hooke spring and bungee force unit in signed fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Content
//  s_*       s_tvalid s_tready s_tdata s_tuser         in         positions, mode
//  m_*       m_tvalid m_tready m_tdata m_tuser         out        force, flags
//  cfg_*     cfg_valid cfg_ready cfg_addr cfg_data     in         register writes
//
// One transaction enters per cycle while the output is not stalled. The square
// root and divider pipelines each work one bit per stage.
// Reset clears all valid bits and loads both registers with 1.0.
// A stalled output holds every stage in place; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module spring_bungee_force #(
    parameter int FRAC_BITS = sbf_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = sbf_pkg::WORD_BITS_DEF,
    localparam int IN_DATA_W  = ((6 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((3 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // particle_x, particle_y, particle_z, other_x, other_y, other_z
    input  logic [IN_DATA_W-1:0]             s_tdata,
    // cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // force_x, force_y, force_z
    output logic [OUT_DATA_W-1:0]            m_tdata,
    // force_applied, saturated
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sbf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sbf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int W     = WORD_BITS;
    localparam int N     = sbf_pkg::AXES;
    localparam int K_W   = sbf_pkg::REG_W;
    localparam int SQ_W  = 2 * W;
    localparam int S_W   = 2 * W + 2;
    localparam int L_W   = W + 1;
    localparam int E_W   = (L_W > K_W) ? L_W : K_W;
    localparam int M_W   = K_W + E_W - FRAC_BITS;
    localparam int MH_W  = M_W - W;
    localparam int P_W   = M_W + W;
    localparam int SB1_W = 1 + N + N * W;
    localparam int SB2_W = 1 + 2 * N;
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

    logic adv;

    // ---------------- configuration registers ----------------
    logic [K_W-1:0] spring_constant_reg;
    logic [K_W-1:0] rest_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_constant_reg <= sbf_pkg::SPRING_CONSTANT_RST;
            rest_length_reg     <= sbf_pkg::REST_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (sbf_pkg::cfg_reg_t'(cfg_addr))
                sbf_pkg::REG_SPRING_CONSTANT: spring_constant_reg <= cfg_data[K_W-1:0];
                sbf_pkg::REG_REST_LENGTH:     rest_length_reg     <= cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: differences ----------------
    logic                       v1_reg, cmd1_reg;
    logic [N-1:0]               neg1_reg;
    logic [N-1:0][W-1:0]        ad1_reg;
    logic [N-1:0]               neg1_next;
    logic [N-1:0][W-1:0]        ad1_next;

    always_comb
    begin
        logic [W:0] d;
        logic [W:0] nd;
        for (int i = 0; i < N; i++)
        begin
            d  = {s_tdata[i*W + W - 1], s_tdata[i*W +: W]}
               - {s_tdata[(i+3)*W + W - 1], s_tdata[(i+3)*W +: W]};
            nd = -d;
            neg1_next[i] = d[W];
            ad1_next[i]  = d[W] ? nd[W-1:0] : d[W-1:0];
        end
    end

    // ---------------- stage 2: squares ----------------
    logic                       v2_reg, cmd2_reg;
    logic [N-1:0]               neg2_reg;
    logic [N-1:0][W-1:0]        ad2_reg;
    logic [N-1:0][SQ_W-1:0]     sq2_reg;

    // ---------------- stage 3: sum of squares ----------------
    logic                       v3_reg, cmd3_reg;
    logic [N-1:0]               neg3_reg;
    logic [N-1:0][W-1:0]        ad3_reg;
    logic [S_W-1:0]             s3_reg;

    // ---------------- square root ----------------
    sbf_pkg::pipe_ctl_t         sqrt_ctl;
    logic                       sqrt_valid;
    logic [L_W-1:0]             sqrt_root;
    logic [SB1_W-1:0]           sqrt_sb;

    assign sqrt_ctl = '{en: adv, valid: v3_reg};

    sbf_sqrt #(
        .IN_W   (S_W),
        .ROOT_W (L_W),
        .SB_W   (SB1_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sqrt_ctl),
        .radicand  (s3_reg),
        .sb_in     ({ad3_reg, neg3_reg, cmd3_reg}),
        .valid_out (sqrt_valid),
        .root      (sqrt_root),
        .sb_out    (sqrt_sb)
    );

    // ---------------- stage 4: mode and extension ----------------
    logic                       v4_reg, app4_reg;
    logic [N-1:0]               dir4_reg;
    logic [N-1:0][W-1:0]        ad4_reg;
    logic [L_W-1:0]             len4_reg;
    logic [E_W-1:0]             ext4_reg;
    logic                       cmd_q;
    logic [E_W-1:0]             len_e, rest_e;
    logic                       app4_next;

    assign cmd_q  = sqrt_sb[0];
    assign len_e  = E_W'(sqrt_root);
    assign rest_e = E_W'(rest_length_reg);
    // A compressed bungee or a zero length yields no force at all.
    assign app4_next = (sqrt_root != '0) && !(cmd_q && (len_e <= rest_e));

    // ---------------- stage 5: magnitude ----------------
    logic                       v5_reg, app5_reg;
    logic [N-1:0]               dir5_reg;
    logic [N-1:0][W-1:0]        ad5_reg;
    logic [L_W-1:0]             len5_reg;
    logic [M_W-1:0]             mag5_reg;
    logic [K_W+E_W-1:0]         ke;

    assign ke = (K_W+E_W)'(spring_constant_reg) * (K_W+E_W)'(ext4_reg);

    // ---------------- stage 6: partial products ----------------
    logic                       v6_reg, app6_reg;
    logic [N-1:0]               dir6_reg;
    logic [L_W-1:0]             len6_reg;
    logic [N-1:0][2*W-1:0]      plo6_reg;
    logic [N-1:0][MH_W+W-1:0]   phi6_reg;

    // ---------------- stage 7: full products ----------------
    logic                       v7_reg, app7_reg;
    logic [N-1:0]               dir7_reg;
    logic [L_W-1:0]             len7_reg;
    logic [N-1:0][P_W-1:0]      prod7_reg;

    // ---------------- stage 8: overflow check ----------------
    logic                       v8_reg, app8_reg;
    logic [N-1:0]               dir8_reg;
    logic [N-1:0]               ovf8_reg;
    logic [L_W-1:0]             len8_reg;
    logic [N-1:0][P_W-1:0]      prod8_reg;
    logic [P_W-1:0]             len_hi;

    // A quotient of 2^W or more cannot fit and saturates.
    assign len_hi = P_W'(len7_reg) << W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= sqrt_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= s_tuser;
            neg1_reg <= neg1_next;
            ad1_reg  <= ad1_next;

            cmd2_reg <= cmd1_reg;
            neg2_reg <= neg1_reg;
            ad2_reg  <= ad1_reg;
            for (int i = 0; i < N; i++)
            begin
                sq2_reg[i] <= SQ_W'(ad1_reg[i]) * SQ_W'(ad1_reg[i]);
            end

            cmd3_reg <= cmd2_reg;
            neg3_reg <= neg2_reg;
            ad3_reg  <= ad2_reg;
            s3_reg   <= S_W'(sq2_reg[0]) + S_W'(sq2_reg[1]) + S_W'(sq2_reg[2]);

            app4_reg <= app4_next;
            // Spring force points back along d; a stretched bungee along +d.
            dir4_reg <= sqrt_sb[N:1] ^ {N{!cmd_q}};
            ad4_reg  <= sqrt_sb[SB1_W-1:N+1];
            len4_reg <= sqrt_root;
            ext4_reg <= (len_e >= rest_e) ? (len_e - rest_e) : (rest_e - len_e);

            app5_reg <= app4_reg;
            dir5_reg <= dir4_reg;
            ad5_reg  <= ad4_reg;
            len5_reg <= len4_reg;
            mag5_reg <= ke[K_W+E_W-1:FRAC_BITS];

            app6_reg <= app5_reg;
            dir6_reg <= dir5_reg;
            len6_reg <= len5_reg;
            for (int i = 0; i < N; i++)
            begin
                plo6_reg[i] <= (2*W)'(mag5_reg[W-1:0]) * (2*W)'(ad5_reg[i]);
                phi6_reg[i] <= (MH_W+W)'(mag5_reg[M_W-1:W]) * (MH_W+W)'(ad5_reg[i]);
            end

            app7_reg <= app6_reg;
            dir7_reg <= dir6_reg;
            len7_reg <= len6_reg;
            for (int i = 0; i < N; i++)
            begin
                prod7_reg[i] <= P_W'(plo6_reg[i]) + (P_W'(phi6_reg[i]) << W);
            end

            app8_reg  <= app7_reg;
            dir8_reg  <= dir7_reg;
            len8_reg  <= len7_reg;
            prod8_reg <= prod7_reg;
            for (int i = 0; i < N; i++)
            begin
                ovf8_reg[i] <= prod7_reg[i] >= len_hi;
            end
        end
    end

    // ---------------- divider ----------------
    sbf_pkg::pipe_ctl_t         div_ctl;
    logic                       div_valid;
    logic [N-1:0][W-1:0]        div_quo;
    logic [SB2_W-1:0]           div_sb;

    assign div_ctl = '{en: adv, valid: v8_reg};

    sbf_div #(
        .NUM_W (P_W),
        .DEN_W (L_W),
        .QUO_W (W),
        .SB_W  (SB2_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .num       (prod8_reg),
        .den       (len8_reg),
        .sb_in     ({ovf8_reg, dir8_reg, app8_reg}),
        .valid_out (div_valid),
        .quo       (div_quo),
        .sb_out    (div_sb)
    );

    // ---------------- output register ----------------
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;
    logic [1:0]                 out_user_reg;
    logic [OUT_DATA_W-1:0]      out_data_next;
    logic [1:0]                 out_user_next;

    always_comb
    begin
        logic          negative;
        logic          ovf;
        logic          clip;
        logic          any_clip;
        logic [W-1:0]  q;
        logic [W-1:0]  v;
        out_data_next = '0;
        any_clip      = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            q        = div_quo[i];
            negative = div_sb[1 + i];
            ovf      = div_sb[1 + N + i];
            if (negative)
            begin
                clip = ovf || (q > NEG_MAG);
                v    = clip ? NEG_MAG : (W'(0) - q);
            end
            else
            begin
                clip = ovf || q[W-1];
                v    = clip ? POS_MAX : q;
            end
            any_clip = any_clip | clip;
            out_data_next[i*W +: W] = div_sb[0] ? v : '0;
        end
        out_user_next = {div_sb[0] & any_clip, div_sb[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    // The whole pipeline moves whenever the output register can take a transaction.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
